// ===== hdl/rvex_pkg.sv =====
`default_nettype none

package rvex_pkg;

    localparam int unsigned ModeWidth  = 6;
    localparam int unsigned XLen       = 32;
    localparam int unsigned ShamtWidth = 5;

    localparam logic [XLen-1:0] PcStep = 32'd4;

    // instruction kinds, as decoded upstream
    localparam logic [ModeWidth-1:0] MODE_LUI   = 6'd0;
    localparam logic [ModeWidth-1:0] MODE_AUIPC = 6'd1;
    localparam logic [ModeWidth-1:0] MODE_BEQ   = 6'd2;
    localparam logic [ModeWidth-1:0] MODE_BNE   = 6'd3;
    localparam logic [ModeWidth-1:0] MODE_BLT   = 6'd4;
    localparam logic [ModeWidth-1:0] MODE_BGE   = 6'd5;
    localparam logic [ModeWidth-1:0] MODE_BLTU  = 6'd6;
    localparam logic [ModeWidth-1:0] MODE_BGEU  = 6'd7;
    localparam logic [ModeWidth-1:0] MODE_LB    = 6'd8;
    localparam logic [ModeWidth-1:0] MODE_LH    = 6'd9;
    localparam logic [ModeWidth-1:0] MODE_LW    = 6'd10;
    localparam logic [ModeWidth-1:0] MODE_LBU   = 6'd11;
    localparam logic [ModeWidth-1:0] MODE_LHU   = 6'd12;
    localparam logic [ModeWidth-1:0] MODE_SB    = 6'd13;
    localparam logic [ModeWidth-1:0] MODE_SH    = 6'd14;
    localparam logic [ModeWidth-1:0] MODE_SW    = 6'd15;
    localparam logic [ModeWidth-1:0] MODE_ADDI  = 6'd16;
    localparam logic [ModeWidth-1:0] MODE_SLTI  = 6'd17;
    localparam logic [ModeWidth-1:0] MODE_SLTIU = 6'd18;
    localparam logic [ModeWidth-1:0] MODE_XORI  = 6'd19;
    localparam logic [ModeWidth-1:0] MODE_ORI   = 6'd20;
    localparam logic [ModeWidth-1:0] MODE_ANDI  = 6'd21;
    localparam logic [ModeWidth-1:0] MODE_SLLI  = 6'd22;
    localparam logic [ModeWidth-1:0] MODE_SRLI  = 6'd23;
    localparam logic [ModeWidth-1:0] MODE_SRAI  = 6'd24;
    localparam logic [ModeWidth-1:0] MODE_ADD   = 6'd25;
    localparam logic [ModeWidth-1:0] MODE_SUB   = 6'd26;
    localparam logic [ModeWidth-1:0] MODE_SLL   = 6'd27;
    localparam logic [ModeWidth-1:0] MODE_SLT   = 6'd28;
    localparam logic [ModeWidth-1:0] MODE_SLTU  = 6'd29;
    localparam logic [ModeWidth-1:0] MODE_XOR   = 6'd30;
    localparam logic [ModeWidth-1:0] MODE_SRL   = 6'd31;
    localparam logic [ModeWidth-1:0] MODE_SRA   = 6'd32;
    localparam logic [ModeWidth-1:0] MODE_OR    = 6'd33;
    localparam logic [ModeWidth-1:0] MODE_AND   = 6'd34;

    // packed so that the last field sits in the lowest bits
    typedef struct packed {
        logic [XLen-1:0]       instr_pc;
        logic [ShamtWidth-1:0] shift_amount;
        logic [XLen-1:0]       immediate;
        logic [XLen-1:0]       operand_b;
        logic [XLen-1:0]       operand_a;
        logic [ModeWidth-1:0]  mode;
    } ex_in_t;

    typedef struct packed {
        logic            memory_access;
        logic [XLen-1:0] next_pc;
        logic            branch_taken;
        logic [XLen-1:0] result;
    } ex_out_t;

    localparam int unsigned InWidth   = $bits(ex_in_t);
    localparam int unsigned OutWidth  = $bits(ex_out_t);
    localparam int unsigned InTdataW  = ((InWidth + 7) / 8) * 8;
    localparam int unsigned OutTdataW = ((OutWidth + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hdl/rvex_pipe_reg.sv =====
`default_nettype none

// one register slice with valid/ready, full rate while out_ready holds
module rvex_pipe_reg #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;
    logic             load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid && out_data == $past(in_data)))
        else $error("loaded transaction not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled transaction lost or changed");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!load && (!out_valid || out_ready)) |=> !out_valid)
        else $error("transaction appeared without a load");

endmodule

`default_nettype wire

// ===== hdl/rvex_alu.sv =====
`default_nettype none

// result, branch condition and next pc for one decoded instruction
module rvex_alu (
    input  wire rvex_pkg::ex_in_t  item,
    output rvex_pkg::ex_out_t      res
);

    logic [rvex_pkg::XLen-1:0]       a;
    logic [rvex_pkg::XLen-1:0]       b;
    logic [rvex_pkg::XLen-1:0]       imm;
    logic [rvex_pkg::XLen-1:0]       pc;
    logic [rvex_pkg::ShamtWidth-1:0] sh;
    logic [rvex_pkg::ShamtWidth-1:0] bsh;
    logic [rvex_pkg::XLen-1:0]       a_plus_imm;
    logic [rvex_pkg::XLen-1:0]       pc_plus_imm;
    logic                            lt_ab_s;
    logic                            lt_ab_u;
    logic                            lt_ai_s;
    logic                            lt_ai_u;
    logic                            eq_ab;
    logic [rvex_pkg::XLen-1:0]       value;
    logic                            taken;
    logic                            mem;

    assign a   = item.operand_a;
    assign b   = item.operand_b;
    assign imm = item.immediate;
    assign pc  = item.instr_pc;
    assign sh  = item.shift_amount;
    assign bsh = b[rvex_pkg::ShamtWidth-1:0];

    assign a_plus_imm  = a + imm;
    assign pc_plus_imm = pc + imm;
    assign eq_ab   = (a == b);
    assign lt_ab_s = ($signed(a) < $signed(b));
    assign lt_ab_u = (a < b);
    assign lt_ai_s = ($signed(a) < $signed(imm));
    assign lt_ai_u = (a < imm);

    always_comb
    begin
        value = '0;
        taken = 1'b0;
        mem   = 1'b0;
        case (item.mode)
            rvex_pkg::MODE_LUI:   value = imm;
            rvex_pkg::MODE_AUIPC: value = pc_plus_imm;
            rvex_pkg::MODE_BEQ:   taken = eq_ab;
            rvex_pkg::MODE_BNE:   taken = !eq_ab;
            rvex_pkg::MODE_BLT:   taken = lt_ab_s;
            rvex_pkg::MODE_BGE:   taken = !lt_ab_s;
            rvex_pkg::MODE_BLTU:  taken = lt_ab_u;
            rvex_pkg::MODE_BGEU:  taken = !lt_ab_u;
            rvex_pkg::MODE_LB, rvex_pkg::MODE_LH, rvex_pkg::MODE_LW,
            rvex_pkg::MODE_LBU, rvex_pkg::MODE_LHU,
            rvex_pkg::MODE_SB, rvex_pkg::MODE_SH, rvex_pkg::MODE_SW:
            begin
                value = a_plus_imm;
                mem   = 1'b1;
            end
            rvex_pkg::MODE_ADDI:  value = a_plus_imm;
            rvex_pkg::MODE_SLTI:  value = {{(rvex_pkg::XLen-1){1'b0}}, lt_ai_s};
            rvex_pkg::MODE_SLTIU: value = {{(rvex_pkg::XLen-1){1'b0}}, lt_ai_u};
            rvex_pkg::MODE_XORI:  value = a ^ imm;
            rvex_pkg::MODE_ORI:   value = a | imm;
            rvex_pkg::MODE_ANDI:  value = a & imm;
            rvex_pkg::MODE_SLLI:  value = a << sh;
            rvex_pkg::MODE_SRLI:  value = a >> sh;
            rvex_pkg::MODE_SRAI:  value = $unsigned($signed(a) >>> sh);
            rvex_pkg::MODE_ADD:   value = a + b;
            rvex_pkg::MODE_SUB:   value = a - b;
            rvex_pkg::MODE_SLL:   value = a << bsh;
            rvex_pkg::MODE_SLT:   value = {{(rvex_pkg::XLen-1){1'b0}}, lt_ab_s};
            rvex_pkg::MODE_SLTU:  value = {{(rvex_pkg::XLen-1){1'b0}}, lt_ab_u};
            rvex_pkg::MODE_XOR:   value = a ^ b;
            rvex_pkg::MODE_SRL:   value = a >> bsh;
            rvex_pkg::MODE_SRA:   value = $unsigned($signed(a) >>> bsh);
            rvex_pkg::MODE_OR:    value = a | b;
            rvex_pkg::MODE_AND:   value = a & b;
            default:
            begin
                value = '0;
                taken = 1'b0;
                mem   = 1'b0;
            end
        endcase
    end

    assign res.result        = value;
    assign res.branch_taken  = taken;
    assign res.next_pc       = taken ? pc_plus_imm : (pc + rvex_pkg::PcStep);
    assign res.memory_access = mem;

endmodule

`default_nettype wire

// ===== hdl/rv32i_execute_unit.sv =====
`default_nettype none

// channel   | dir | tdata fields (lowest bit up)                            | tuser/tlast
// ----------+-----+---------------------------------------------------------+------------
// s_axis    | in  | mode[5:0] operand_a[37:6] operand_b[69:38]              | none
//           |     | immediate[101:70] shift_amount[106:102] instr_pc[138:107]|
// m_axis    | out | result[31:0] branch_taken[32] next_pc[64:33]            | none
//           |     | memory_access[65]                                       |
//
// one transaction in and one out per cycle, sustained while m_axis_tready stays high
// a transaction passes the input register, then the alu and the result register
// the logic ahead of the result register (one 32-bit add/compare and the
//   result select) sets the clock
// reset clears both valid bits only; payload registers are not reset
// a stall on m_axis ripples back through each register's ready, a slot frees
//   in the same cycle its transaction leaves, so no bubbles are inserted

module rv32i_execute_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // mode, operand_a, operand_b, immediate, shift_amount, instr_pc, zero pad
    input  wire logic [rvex_pkg::InTdataW-1:0]       s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // result, branch_taken, next_pc, memory_access, zero pad
    output logic [rvex_pkg::OutTdataW-1:0]           m_axis_tdata
);

    rvex_pkg::ex_in_t  in_item;
    rvex_pkg::ex_in_t  stage_item;
    rvex_pkg::ex_out_t alu_res;
    rvex_pkg::ex_out_t out_item;
    logic              stage_valid;
    logic              stage_ready;

    assign in_item = rvex_pkg::ex_in_t'(s_axis_tdata[rvex_pkg::InWidth-1:0]);

    // input register: decoded instruction waits here for the alu
    rvex_pipe_reg #(
        .WIDTH (rvex_pkg::InWidth)
    ) u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (stage_valid),
        .out_ready (stage_ready),
        .out_data  (stage_item)
    );

    // single pass through the alu, branch compare and next-pc adders
    rvex_alu u_alu (
        .item (stage_item),
        .res  (alu_res)
    );

    // result register: holds a finished transaction while m_axis stalls
    rvex_pipe_reg #(
        .WIDTH (rvex_pkg::OutWidth)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid),
        .in_ready  (stage_ready),
        .in_data   (alu_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_item)
    );

    assign m_axis_tdata = {{(rvex_pkg::OutTdataW - rvex_pkg::OutWidth){1'b0}}, out_item};

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && stage_ready) |=> (m_axis_tvalid && out_item == $past(alu_res)))
        else $error("alu result not captured");

    a_mem_no_branch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_item.memory_access && out_item.branch_taken))
        else $error("memory access flagged as taken branch");

    a_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_item.branch_taken) |-> (out_item.result == '0))
        else $error("taken branch carries a non-zero result");

endmodule

`default_nettype wire

// ===== sim/rv32i_execute_unit_checker.sv =====
`default_nettype none

// passive checker: predicts each accepted instruction and compares the m_axis stream
module rv32i_execute_unit_checker
    import rvex_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    // mode, operand_a, operand_b, immediate, shift_amount, instr_pc, zero pad
    input  wire logic [InTdataW-1:0]  s_axis_tdata,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // result, branch_taken, next_pc, memory_access, zero pad
    input  wire logic [OutTdataW-1:0] m_axis_tdata,
    output int unsigned               fail_count,
    output int unsigned               in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    ex_out_t     pending_results[$];
    ex_out_t     wanted;
    ex_out_t     seen;
    int unsigned errors = 0;

    // execute-stage behaviour of one decoded instruction
    function automatic ex_out_t predict_execute(input ex_in_t op);
        ex_out_t         outcome;
        logic [XLen-1:0] a;
        logic [XLen-1:0] b;
        logic [XLen-1:0] imm;
        logic [XLen-1:0] res;
        logic            taken;
        logic            mem;
        a     = op.operand_a;
        b     = op.operand_b;
        imm   = op.immediate;
        res   = '0;
        taken = 1'b0;
        mem   = 1'b0;
        case (op.mode)
            MODE_LUI:   res = imm;
            MODE_AUIPC: res = op.instr_pc + imm;
            MODE_BEQ:   taken = (a == b);
            MODE_BNE:   taken = (a != b);
            MODE_BLT:   taken = ($signed(a) < $signed(b));
            MODE_BGE:   taken = !($signed(a) < $signed(b));
            MODE_BLTU:  taken = (a < b);
            MODE_BGEU:  taken = (a >= b);
            MODE_LB, MODE_LH, MODE_LW, MODE_LBU, MODE_LHU, MODE_SB, MODE_SH, MODE_SW:
            begin
                res = a + imm;
                mem = 1'b1;
            end
            MODE_ADDI:  res = a + imm;
            MODE_SLTI:  res = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
            MODE_SLTIU: res = (a < imm) ? 32'd1 : 32'd0;
            MODE_XORI:  res = a ^ imm;
            MODE_ORI:   res = a | imm;
            MODE_ANDI:  res = a & imm;
            MODE_SLLI:  res = a << op.shift_amount;
            MODE_SRLI:  res = a >> op.shift_amount;
            MODE_SRAI:  res = $unsigned($signed(a) >>> op.shift_amount);
            MODE_ADD:   res = a + b;
            MODE_SUB:   res = a - b;
            MODE_SLL:   res = a << b[ShamtWidth-1:0];
            MODE_SLT:   res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            MODE_SLTU:  res = (a < b) ? 32'd1 : 32'd0;
            MODE_XOR:   res = a ^ b;
            MODE_SRL:   res = a >> b[ShamtWidth-1:0];
            MODE_SRA:   res = $unsigned($signed(a) >>> b[ShamtWidth-1:0]);
            MODE_OR:    res = a | b;
            MODE_AND:   res = a & b;
            default:    res = '0;
        endcase
        outcome.result        = res;
        outcome.branch_taken  = taken;
        outcome.next_pc       = taken ? (op.instr_pc + imm) : (op.instr_pc + PcStep);
        outcome.memory_access = mem;
        return outcome;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_execute(s_axis_tdata[InWidth-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[OutWidth-1:0];
                if (pending_results.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: unexpected result transaction", $realtime);
                        $display("  result %h taken %b next_pc %h mem %b",
                                 seen.result, seen.branch_taken, seen.next_pc,
                                 seen.memory_access);
                    end
                    errors++;
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (seen.result !== wanted.result
                        || seen.branch_taken !== wanted.branch_taken
                        || seen.next_pc !== wanted.next_pc
                        || seen.memory_access !== wanted.memory_access)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: result transaction differs (exp/got)",
                                     $realtime);
                            $display("  result %h/%h taken %b/%b next_pc %h/%h mem %b/%b",
                                     wanted.result, seen.result,
                                     wanted.branch_taken, seen.branch_taken,
                                     wanted.next_pc, seen.next_pc,
                                     wanted.memory_access, seen.memory_access);
                        end
                        errors++;
                    end
                end
            end
            fail_count <= errors;
            in_flight  <= pending_results.size();
        end
        else
        begin
            fail_count <= errors;
            in_flight  <= 0;
        end
    end

endmodule

`default_nettype wire

// ===== sim/rv32i_execute_unit_tb.sv =====
`default_nettype none

// stimulus and verdict for the execute unit; all checking lives in the checker
module rv32i_execute_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvex_pkg::*;

    localparam int unsigned CycleLimit    = 400000;
    localparam int unsigned HoldOffCycles = 120;
    localparam int unsigned DrainCycles   = 10;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // mode, operand_a, operand_b, immediate, shift_amount, instr_pc, zero pad
    logic [InTdataW-1:0]  s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // result, branch_taken, next_pc, memory_access, zero pad
    logic [OutTdataW-1:0] m_axis_tdata;

    int unsigned fail_count;
    int unsigned in_flight;
    int unsigned cycle_count   = 0;
    // no random idling on either side while set; a requested hold-off still applies
    bit          steady        = 1'b0;
    // asks the receiver for one long hold-off
    bit          hold_off_req  = 1'b0;

    rv32i_execute_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rv32i_execute_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .in_flight     (in_flight)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // idle length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // operand values, biased towards the corners of the 32-bit range
    function automatic logic [XLen-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom_range(0, 63);
            5:       return 32'hffff_ffff - $urandom_range(0, 63);
            default: return $urandom;
        endcase
    endfunction

    function automatic ex_in_t make_op(input logic [ModeWidth-1:0]  kind,
                                       input logic [XLen-1:0]       a,
                                       input logic [XLen-1:0]       b,
                                       input logic [XLen-1:0]       imm,
                                       input logic [ShamtWidth-1:0] sh,
                                       input logic [XLen-1:0]       pc);
        ex_in_t op;
        op.mode         = kind;
        op.operand_a    = a;
        op.operand_b    = b;
        op.immediate    = imm;
        op.shift_amount = sh;
        op.instr_pc     = pc;
        return op;
    endfunction

    // random instruction: mostly legal kinds, a few undefined codes
    function automatic ex_in_t random_op();
        ex_in_t op;
        op.mode         = ModeWidth'(($urandom_range(0, 99) < 94)
                                     ? $urandom_range(MODE_LUI, MODE_AND)
                                     : $urandom_range(MODE_AND + 1, 63));
        op.operand_a    = pick_word();
        op.operand_b    = pick_word();
        op.immediate    = pick_word();
        op.shift_amount = ShamtWidth'($urandom_range(0, 31));
        op.instr_pc     = pick_word();
        // equal operands so that equality branches and compares go both ways
        if ($urandom_range(0, 4) == 0)
            op.operand_b = op.operand_a;
        if ($urandom_range(0, 7) == 0)
            op.immediate = op.operand_a;
        return op;
    endfunction

    // offer one transaction from a falling edge, return at the falling edge after acceptance
    task automatic send_op(input ex_in_t op);
        s_axis_tdata  <= {{(InTdataW - InWidth){1'b0}}, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // sender idles after a transaction, unless in a steady phase
    task automatic sender_gap();
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        while (in_flight != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(input int unsigned count, input int unsigned hold_at);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_off_req = 1'b1;
            send_op(random_op());
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: random back-pressure, one long hold-off on request, counted here
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HoldOffCycles;
            end
            else if (stall_left == 0 && !steady)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        // reset held from the start, released on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, wrap-around, signed against unsigned, undefined kinds
        send_op(make_op(MODE_LUI,   '0, '0, 32'h8000_0000, 5'd0, 32'h0000_0000));
        send_op(make_op(MODE_LUI,   '1, '1, 32'hffff_f000, 5'd31, 32'hffff_ffff));
        // auipc address wraps past the top
        send_op(make_op(MODE_AUIPC, '0, '0, 32'd8, 5'd0, 32'hffff_fffc));
        // taken branch with a negative offset below zero
        send_op(make_op(MODE_BEQ,   '1, '1, 32'hffff_fff8, 5'd0, 32'h0000_0000));
        send_op(make_op(MODE_BEQ,   32'd1, 32'd0, 32'h0000_0010, 5'd0, 32'h0000_1000));
        send_op(make_op(MODE_BNE,   32'd0, 32'd1, 32'h7fff_fffe, 5'd0, 32'h8000_0000));
        // most negative against most positive, signed then unsigned
        send_op(make_op(MODE_BLT,   32'h8000_0000, 32'h7fff_ffff, 32'd64, 5'd0, 32'h100));
        send_op(make_op(MODE_BGE,   32'h7fff_ffff, 32'h8000_0000, 32'd64, 5'd0, 32'h100));
        send_op(make_op(MODE_BLTU,  32'h7fff_ffff, 32'h8000_0000, 32'd64, 5'd0, 32'h100));
        send_op(make_op(MODE_BGEU,  32'h0000_0000, 32'hffff_ffff, 32'd64, 5'd0, 32'h100));
        // effective addresses: one that wraps past the top, two that land near the top
        send_op(make_op(MODE_LB,    32'hffff_ffff, '0, 32'd1, 5'd0, 32'h0));
        send_op(make_op(MODE_LW,    32'h0000_0000, '0, 32'hffff_fffc, 5'd0, 32'h0));
        send_op(make_op(MODE_SW,    32'h8000_0000, '1, 32'h7fff_ffff, 5'd0, 32'h0));
        send_op(make_op(MODE_SLTI,  32'hffff_ffff, '0, 32'h0000_0000, 5'd0, 32'h0));
        // sign-extended immediate read as unsigned
        send_op(make_op(MODE_SLTIU, 32'h0000_0000, '0, 32'hffff_ffff, 5'd0, 32'h0));
        send_op(make_op(MODE_SLLI,  32'h0000_0001, '0, '0, 5'd31, 32'h0));
        send_op(make_op(MODE_SRAI,  32'h8000_0000, '0, '0, 5'd31, 32'h0));
        send_op(make_op(MODE_SRLI,  32'hffff_ffff, '0, '0, 5'd0, 32'h0));
        // register shifts take only the low five bits of rs2
        send_op(make_op(MODE_SRA,   32'h8000_0000, 32'hffff_ffe4, '0, 5'd0, 32'h0));
        send_op(make_op(MODE_SLL,   32'h0000_0001, 32'hffff_ffff, '0, 5'd0, 32'h0));
        send_op(make_op(MODE_SUB,   32'h0000_0000, 32'h0000_0001, '0, 5'd0, 32'h0));
        send_op(make_op(MODE_ADD,   32'hffff_ffff, 32'h0000_0001, '0, 5'd0, 32'h0));
        send_op(make_op(MODE_SLT,   32'h0000_0001, 32'hffff_ffff, '0, 5'd0, 32'h0));
        send_op(make_op(MODE_SLTU,  32'h0000_0001, 32'hffff_ffff, '0, 5'd0, 32'h0));
        // undefined kinds: lowest and highest code
        send_op(make_op(MODE_AND + 6'd1, '1, '1, '1, 5'd31, 32'hffff_fffc));
        send_op(make_op(6'h3f,           '1, '1, '1, 5'd31, 32'hffff_ffff));
        s_axis_tvalid <= 1'b0;

        // random with idling on both sides, then a full drain before moving on
        @(negedge clk);
        run_random(300, 32'hffff_ffff);
        wait_for_drain();

        // back-to-back phase: receiver holds off while the sender keeps offering
        steady = 1'b1;
        run_random(200, 40);
        wait_for_drain();
        steady = 1'b0;

        run_random(400, 32'hffff_ffff);

        wait_for_drain();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/rvex_pkg.sv
hdl/rvex_pipe_reg.sv
hdl/rvex_alu.sv
hdl/rv32i_execute_unit.sv
sim/rv32i_execute_unit_checker.sv
sim/rv32i_execute_unit_tb.sv
